// ===== hdl/frt_pkg.sv =====
// Shared types and constants for the frame slot ring tracker.
package frt_pkg;

    localparam int CMD_W  = 3;
    localparam int CFG_W  = 5;
    localparam int SLOT_W = 4;
    localparam int OUT_DESC_W = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_WR_RAW      = 3'd0,
        CMD_RD_RAW_DET  = 3'd1,
        CMD_RD_RAW_DISP = 3'd2,
        CMD_WR_DET      = 3'd3,
        CMD_RD_DET      = 3'd4,
        CMD_WR_DISP     = 3'd5,
        CMD_RD_DISP     = 3'd6
    } t_cmd;

    // Which descriptor store feeds the result of a transaction.
    typedef enum logic [1:0] {
        SRC_NONE = 2'd0,
        SRC_RAW  = 2'd1,
        SRC_DET  = 2'd2,
        SRC_DISP = 2'd3
    } t_src;

endpackage

// ===== hdl/frame_slot_ring_tracker.sv =====
// Frame slot ring tracker: raw, detection and display rings with per-slot full flags.
//
// Usage:
//   Input channel (i_valid / o_ready) carries one command and a descriptor per
//   transaction. Writes store the descriptor at the ring's write head if that slot
//   is empty; reads return the descriptor at the read head if the slot is full.
//   Raw reads keep the flag; detection and display reads clear it, and a display
//   read also frees the raw slot with the same index.
//   Output channel (o_valid / i_ready) returns ok, the slot tested and the
//   descriptor read (zero unless a read succeeded), one result per command.
//   Config channel (i_cfg_valid / o_cfg_ready, always ready) sets slots_in_use;
//   write it only while no transaction is in flight.
// Timing:
//   o_valid rises when the result register loads: the flag test and head
//   update are done in the accept cycle, the accept edge loads stage 1 and the
//   store read data, then stage 1 moves into the result register. Throughput is
//   one transaction per cycle without stalls, as each command needs one flag test
//   and head update. When the receiver stalls, the result and one in-flight
//   transaction hold and o_ready drops once both stages are occupied.
// Reset: synchronous, active low; clears all flags and heads and sets
//   slots_in_use to 16. Descriptor RAMs are not cleared.
module frame_slot_ring_tracker
    import frt_pkg::*;
#(
    parameter int MAX_SLOTS = 16,
    parameter int DESC_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [CMD_W-1:0]      i_cmd,
    input  logic [31:0]           i_descriptor,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_ok,
    output logic [SLOT_W-1:0]     o_slot,
    output logic [OUT_DESC_W-1:0] o_read_descriptor,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_W-1:0]      i_cfg_slots_in_use
);

    localparam int HW = $clog2(MAX_SLOTS);
    localparam int LW = $clog2(MAX_SLOTS + 1);
    localparam int XW = (LW > CFG_W) ? LW : CFG_W;

    typedef logic [HW-1:0] t_head;

    // Ring state
    logic [CFG_W-1:0]     r_slots_in_use;
    logic [MAX_SLOTS-1:0] r_raw_full, n_raw_full;
    logic [MAX_SLOTS-1:0] r_det_full, n_det_full;
    logic [MAX_SLOTS-1:0] r_disp_full, n_disp_full;
    t_head r_raw_wr_head, n_raw_wr_head;
    t_head r_raw_det_head, n_raw_det_head;
    t_head r_raw_disp_head, n_raw_disp_head;
    t_head r_det_wr_head, n_det_wr_head;
    t_head r_det_rd_head, n_det_rd_head;
    t_head r_disp_wr_head, n_disp_wr_head;
    t_head r_disp_rd_head, n_disp_rd_head;

    // Pipeline
    logic  r_s1_valid;
    logic  r_s1_ok;
    t_head r_s1_slot;
    t_src  r_s1_src;
    logic                  r_o_valid;
    logic                  r_o_ok;
    logic [SLOT_W-1:0]     r_o_slot;
    logic [OUT_DESC_W-1:0] r_o_desc;

    logic  in_acc;
    logic  s1_adv;
    logic  acc_ok;
    t_head acc_slot;
    t_src  acc_src;
    logic [XW-1:0] ring_len;
    logic [XW-1:0] cfg_ext;

    logic  raw_we, det_we, disp_we;
    logic  raw_re, det_re, disp_re;
    t_head raw_waddr, det_waddr, disp_waddr;
    t_head raw_raddr, det_raddr, disp_raddr;
    logic [DESC_BITS-1:0] wdata;
    logic [DESC_BITS-1:0] raw_rdata, det_rdata, disp_rdata;
    logic [DESC_BITS-1:0] s1_desc;

    function automatic t_head advance(input t_head head, input logic [XW-1:0] len);
        logic [XW-1:0] nxt;
        nxt = XW'(head) + XW'(1);
        return (nxt >= len) ? '0 : HW'(nxt);
    endfunction

    assign s1_adv      = !r_o_valid || i_ready;
    assign o_ready     = !r_s1_valid || s1_adv;
    assign in_acc      = i_valid && o_ready;
    assign o_cfg_ready = 1'b1;
    assign wdata       = DESC_BITS'(i_descriptor);

    // Zero acts as one, anything past the ring size acts as the ring size.
    assign cfg_ext  = XW'(r_slots_in_use);
    assign ring_len = (cfg_ext == '0) ? XW'(1) :
                      (cfg_ext > XW'(MAX_SLOTS)) ? XW'(MAX_SLOTS) : cfg_ext;

    always_comb begin
        n_raw_full      = r_raw_full;
        n_det_full      = r_det_full;
        n_disp_full     = r_disp_full;
        n_raw_wr_head   = r_raw_wr_head;
        n_raw_det_head  = r_raw_det_head;
        n_raw_disp_head = r_raw_disp_head;
        n_det_wr_head   = r_det_wr_head;
        n_det_rd_head   = r_det_rd_head;
        n_disp_wr_head  = r_disp_wr_head;
        n_disp_rd_head  = r_disp_rd_head;
        acc_ok     = 1'b0;
        acc_slot   = '0;
        acc_src    = SRC_NONE;
        raw_we     = 1'b0;
        det_we     = 1'b0;
        disp_we    = 1'b0;
        raw_re     = 1'b0;
        det_re     = 1'b0;
        disp_re    = 1'b0;
        raw_waddr  = r_raw_wr_head;
        det_waddr  = r_det_wr_head;
        disp_waddr = r_disp_wr_head;
        raw_raddr  = r_raw_det_head;
        det_raddr  = r_det_rd_head;
        disp_raddr = r_disp_rd_head;
        if (in_acc) begin
            unique case (t_cmd'(i_cmd))
                CMD_WR_RAW: begin
                    acc_slot = r_raw_wr_head;
                    if (!r_raw_full[r_raw_wr_head]) begin
                        acc_ok = 1'b1;
                        raw_we = 1'b1;
                        n_raw_full[r_raw_wr_head] = 1'b1;
                        n_raw_wr_head = advance(r_raw_wr_head, ring_len);
                    end
                end
                CMD_RD_RAW_DET: begin
                    acc_slot  = r_raw_det_head;
                    raw_raddr = r_raw_det_head;
                    if (r_raw_full[r_raw_det_head]) begin
                        acc_ok  = 1'b1;
                        acc_src = SRC_RAW;
                        raw_re  = 1'b1;
                        n_raw_det_head = advance(r_raw_det_head, ring_len);
                    end
                end
                CMD_RD_RAW_DISP: begin
                    acc_slot  = r_raw_disp_head;
                    raw_raddr = r_raw_disp_head;
                    if (r_raw_full[r_raw_disp_head]) begin
                        acc_ok  = 1'b1;
                        acc_src = SRC_RAW;
                        raw_re  = 1'b1;
                        n_raw_disp_head = advance(r_raw_disp_head, ring_len);
                    end
                end
                CMD_WR_DET: begin
                    acc_slot = r_det_wr_head;
                    if (!r_det_full[r_det_wr_head]) begin
                        acc_ok = 1'b1;
                        det_we = 1'b1;
                        n_det_full[r_det_wr_head] = 1'b1;
                        n_det_wr_head = advance(r_det_wr_head, ring_len);
                    end
                end
                CMD_RD_DET: begin
                    acc_slot = r_det_rd_head;
                    if (r_det_full[r_det_rd_head]) begin
                        acc_ok  = 1'b1;
                        acc_src = SRC_DET;
                        det_re  = 1'b1;
                        n_det_full[r_det_rd_head] = 1'b0;
                        n_det_rd_head = advance(r_det_rd_head, ring_len);
                    end
                end
                CMD_WR_DISP: begin
                    acc_slot = r_disp_wr_head;
                    if (!r_disp_full[r_disp_wr_head]) begin
                        acc_ok  = 1'b1;
                        disp_we = 1'b1;
                        n_disp_full[r_disp_wr_head] = 1'b1;
                        n_disp_wr_head = advance(r_disp_wr_head, ring_len);
                    end
                end
                CMD_RD_DISP: begin
                    acc_slot = r_disp_rd_head;
                    if (r_disp_full[r_disp_rd_head]) begin
                        acc_ok  = 1'b1;
                        acc_src = SRC_DISP;
                        disp_re = 1'b1;
                        // consuming a displayed frame releases its raw slot too
                        n_disp_full[r_disp_rd_head] = 1'b0;
                        n_raw_full[r_disp_rd_head]  = 1'b0;
                        n_disp_rd_head = advance(r_disp_rd_head, ring_len);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    frt_ram #(.WIDTH(DESC_BITS), .DEPTH(MAX_SLOTS)) u_raw_ram (
        .i_clk  (i_clk),
        .i_we   (raw_we),
        .i_waddr(raw_waddr),
        .i_wdata(wdata),
        .i_re   (raw_re),
        .i_raddr(raw_raddr),
        .o_rdata(raw_rdata)
    );

    frt_ram #(.WIDTH(DESC_BITS), .DEPTH(MAX_SLOTS)) u_det_ram (
        .i_clk  (i_clk),
        .i_we   (det_we),
        .i_waddr(det_waddr),
        .i_wdata(wdata),
        .i_re   (det_re),
        .i_raddr(det_raddr),
        .o_rdata(det_rdata)
    );

    frt_ram #(.WIDTH(DESC_BITS), .DEPTH(MAX_SLOTS)) u_disp_ram (
        .i_clk  (i_clk),
        .i_we   (disp_we),
        .i_waddr(disp_waddr),
        .i_wdata(wdata),
        .i_re   (disp_re),
        .i_raddr(disp_raddr),
        .o_rdata(disp_rdata)
    );

    // RAM read data holds while stage 1 is stalled: no new read is issued then.
    always_comb begin
        unique case (r_s1_src)
            SRC_RAW:  s1_desc = raw_rdata;
            SRC_DET:  s1_desc = det_rdata;
            SRC_DISP: s1_desc = disp_rdata;
            default:  s1_desc = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots_in_use  <= CFG_W'(16);
            r_raw_full      <= '0;
            r_det_full      <= '0;
            r_disp_full     <= '0;
            r_raw_wr_head   <= '0;
            r_raw_det_head  <= '0;
            r_raw_disp_head <= '0;
            r_det_wr_head   <= '0;
            r_det_rd_head   <= '0;
            r_disp_wr_head  <= '0;
            r_disp_rd_head  <= '0;
            r_s1_valid      <= 1'b0;
            r_o_valid       <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_slots_in_use <= i_cfg_slots_in_use;
            end
            r_raw_full      <= n_raw_full;
            r_det_full      <= n_det_full;
            r_disp_full     <= n_disp_full;
            r_raw_wr_head   <= n_raw_wr_head;
            r_raw_det_head  <= n_raw_det_head;
            r_raw_disp_head <= n_raw_disp_head;
            r_det_wr_head   <= n_det_wr_head;
            r_det_rd_head   <= n_det_rd_head;
            r_disp_wr_head  <= n_disp_wr_head;
            r_disp_rd_head  <= n_disp_rd_head;
            if (o_ready) begin
                r_s1_valid <= i_valid;
            end
            if (s1_adv) begin
                r_o_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_ok   <= acc_ok;
            r_s1_slot <= acc_slot;
            r_s1_src  <= acc_src;
        end
        if (r_s1_valid && s1_adv) begin
            r_o_ok   <= r_s1_ok;
            r_o_slot <= SLOT_W'(r_s1_slot);
            r_o_desc <= OUT_DESC_W'(s1_desc);
        end
    end

    assign o_valid           = r_o_valid;
    assign o_ok              = r_o_ok;
    assign o_slot            = r_o_slot;
    assign o_read_descriptor = r_o_desc;

`ifndef SYNTHESIS
    a_fail_no_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !r_s1_ok |-> r_s1_src == SRC_NONE)
        else $error("failed transaction selects a descriptor store");

    a_raw_write_sets_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (t_cmd'(i_cmd) == CMD_WR_RAW) |=> r_raw_full[$past(r_raw_wr_head)])
        else $error("raw write left its slot empty");

    a_disp_read_frees_raw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (t_cmd'(i_cmd) == CMD_RD_DISP) && r_disp_full[r_disp_rd_head]
        |=> !r_raw_full[$past(r_disp_rd_head)] && !r_disp_full[$past(r_disp_rd_head)])
        else $error("display read did not free its slots");

    a_heads_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_raw_wr_head) < MAX_SLOTS && 32'(r_det_rd_head) < MAX_SLOTS &&
        32'(r_disp_rd_head) < MAX_SLOTS)
        else $error("ring head outside the slot range");

    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s1_adv |=> r_s1_valid && $stable(r_s1_slot) && $stable(s1_desc))
        else $error("stalled transaction lost in stage 1");
`endif

endmodule

// ===== hdl/frt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module frt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sim/frame_slot_ring_tracker_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the frame slot ring tracker.
module frame_slot_ring_tracker_tb
    import frt_pkg::*;
();

    localparam int               NUM_SLOTS   = 16;
    localparam int               CYCLE_LIMIT = 300000;
    localparam int               LONG_HOLD   = 60;
    localparam logic [CMD_W-1:0] CMD_NOP     = 3'd7;

    localparam int RING_RAW  = 0;
    localparam int RING_DET  = 1;
    localparam int RING_DISP = 2;

    localparam int HD_RAW_DET  = 0;
    localparam int HD_RAW_DISP = 1;
    localparam int HD_DET      = 2;
    localparam int HD_DISP     = 3;

    typedef struct packed {
        logic                  ok;
        logic [SLOT_W-1:0]     slot;
        logic [OUT_DESC_W-1:0] desc;
    } t_slot_result;

    logic                  i_clk              = 1'b0;
    logic                  i_rst_n            = 1'b0;
    logic                  i_valid            = 1'b0;
    logic                  o_ready;
    logic [CMD_W-1:0]      i_cmd              = '0;
    logic [31:0]           i_descriptor       = '0;
    logic                  o_valid;
    logic                  i_ready            = 1'b0;
    logic                  o_ok;
    logic [SLOT_W-1:0]     o_slot;
    logic [OUT_DESC_W-1:0] o_read_descriptor;
    logic                  i_cfg_valid        = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_W-1:0]      i_cfg_slots_in_use = '0;

    // Predicted ring state
    logic [CFG_W-1:0]  ring_cfg;
    bit                slot_full [3][NUM_SLOTS];
    logic [31:0]       slot_desc [3][NUM_SLOTS];
    logic [SLOT_W-1:0] wr_head   [3];
    logic [SLOT_W-1:0] rd_head   [4];
    t_slot_result      pending_results [$];

    int  err_cnt         = 0;
    int  cmds_sent       = 0;
    int  results_checked = 0;
    int  ok_cnt          = 0;
    int  cfg_writes      = 0;
    int  cycle_cnt       = 0;
    int  burst_left      = 0;
    bit  hold_req        = 1'b0;
    int  hold_left       = 0;
    int  rx_mode         = 0;
    int  rx_mode_left    = 0;

    frame_slot_ring_tracker u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_cmd              (i_cmd),
        .i_descriptor       (i_descriptor),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_ok               (o_ok),
        .o_slot             (o_slot),
        .o_read_descriptor  (o_read_descriptor),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_slots_in_use (i_cfg_slots_in_use)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Out-of-range sizes clamp: 0 behaves as 1, anything above 16 as 16.
    // A head left beyond a shrunken ring wraps to 0 on its next advance.
    function automatic logic [SLOT_W-1:0] step_head(logic [SLOT_W-1:0] head);
        int len;
        int nxt;
        len = (ring_cfg == 0) ? 1 : (ring_cfg > NUM_SLOTS) ? NUM_SLOTS : int'(ring_cfg);
        nxt = int'(head) + 1;
        return (nxt >= len) ? '0 : SLOT_W'(nxt);
    endfunction

    function automatic t_slot_result track_frame_cmd(logic [CMD_W-1:0] cmd,
                                                     logic [31:0] desc);
        t_slot_result res;
        int           ring;
        int           hd;
        bit           is_wr;
        bit           clr;
        res   = '0;
        ring  = RING_RAW;
        hd    = HD_RAW_DET;
        is_wr = 1'b0;
        clr   = 1'b0;
        case (cmd)
            CMD_WR_RAW:      is_wr = 1'b1;
            CMD_RD_RAW_DET:  hd = HD_RAW_DET;
            CMD_RD_RAW_DISP: hd = HD_RAW_DISP;
            CMD_WR_DET: begin
                ring  = RING_DET;
                is_wr = 1'b1;
            end
            CMD_RD_DET: begin
                ring = RING_DET;
                hd   = HD_DET;
                clr  = 1'b1;
            end
            CMD_WR_DISP: begin
                ring  = RING_DISP;
                is_wr = 1'b1;
            end
            CMD_RD_DISP: begin
                ring = RING_DISP;
                hd   = HD_DISP;
                clr  = 1'b1;
            end
            default: return res;
        endcase
        if (is_wr) begin
            res.slot = wr_head[ring];
            if (!slot_full[ring][res.slot]) begin
                slot_desc[ring][res.slot] = desc;
                slot_full[ring][res.slot] = 1'b1;
                wr_head[ring]             = step_head(wr_head[ring]);
                res.ok                    = 1'b1;
            end
        end else begin
            res.slot = rd_head[hd];
            if (slot_full[ring][res.slot]) begin
                res.ok   = 1'b1;
                res.desc = slot_desc[ring][res.slot];
                if (clr) slot_full[ring][res.slot] = 1'b0;
                // display consumption releases the raw frame at the same index
                if (cmd == CMD_RD_DISP) slot_full[RING_RAW][res.slot] = 1'b0;
                rd_head[hd] = step_head(rd_head[hd]);
            end
        end
        return res;
    endfunction

    // Prediction and result checking, sampled at the clock edge
    always @(posedge i_clk) begin : scoreboard
        t_slot_result exp_res;
        if (!i_rst_n) begin
            ring_cfg = 5'd16;
            for (int r = 0; r < 3; r++) begin
                wr_head[r] = '0;
                for (int s = 0; s < NUM_SLOTS; s++) slot_full[r][s] = 1'b0;
            end
            for (int h = 0; h < 4; h++) rd_head[h] = '0;
            pending_results.delete();
        end else begin
            if (o_valid && i_ready) begin
                if (pending_results.size() == 0) begin
                    $error("result transaction with nothing outstanding: ok=%0d slot=%0d",
                           o_ok, o_slot);
                    err_cnt++;
                end else begin
                    exp_res = pending_results.pop_front();
                    results_checked++;
                    if (exp_res.ok) ok_cnt++;
                    if (o_ok !== exp_res.ok) begin
                        $error("ok mismatch: expected %0d, got %0d", exp_res.ok, o_ok);
                        err_cnt++;
                    end
                    if (o_slot !== exp_res.slot) begin
                        $error("slot mismatch: expected %0d, got %0d", exp_res.slot, o_slot);
                        err_cnt++;
                    end
                    if (o_read_descriptor !== exp_res.desc) begin
                        $error("read_descriptor mismatch: expected 0x%08h, got 0x%08h",
                               exp_res.desc, o_read_descriptor);
                        err_cnt++;
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) ring_cfg = i_cfg_slots_in_use;
            if (i_valid && o_ready)
                pending_results = {pending_results, track_frame_cmd(i_cmd, i_descriptor)};
        end
    end

    // Receiver: stall pattern changes mode every so often; long hold on request
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_left = LONG_HOLD;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      = $urandom_range(0, 3);
                rx_mode_left = $urandom_range(20, 120);
            end
            rx_mode_left--;
            case (rx_mode)
                0:       i_ready <= 1'b1;
                1:       i_ready <= ($urandom_range(0, 1) == 1);
                2:       i_ready <= ($urandom_range(0, 9) != 0);
                default: i_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    function automatic logic [31:0] rand_desc();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return $urandom();
        endcase
    endfunction

    // Sender works in bursts; valid stays up across back-to-back transactions
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [31:0] desc);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid      <= 1'b1;
        i_cmd        <= cmd;
        i_descriptor <= desc;
        do @(posedge i_clk); while (!o_ready);
        cmds_sent++;
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_ring_size(input logic [CFG_W-1:0] size);
        wait_idle();
        i_cfg_valid        <= 1'b1;
        i_cfg_slots_in_use <= size;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    // k frames through the full raw -> detection -> display flow
    task automatic send_frames(input int k);
        repeat (k) send_item(CMD_WR_RAW, rand_desc());
        repeat (k) begin
            send_item(CMD_RD_RAW_DET, rand_desc());
            send_item(CMD_WR_DET, rand_desc());
            send_item(CMD_RD_DET, rand_desc());
        end
        repeat (k) begin
            send_item(CMD_RD_RAW_DISP, rand_desc());
            send_item(CMD_WR_DISP, rand_desc());
            send_item(CMD_RD_DISP, rand_desc());
        end
    endtask

    task automatic run_traffic(input int n);
        int start;
        start = cmds_sent;
        while (cmds_sent - start < n) begin
            if ($urandom_range(0, 3) != 0)
                send_frames($urandom_range(1, 4));
            else
                repeat ($urandom_range(1, 6))
                    send_item(CMD_W'($urandom_range(0, 7)), rand_desc());
        end
    endtask

    task automatic test_directed();
        set_ring_size(5'd2);
        // reads on empty rings
        send_item(CMD_RD_RAW_DET, 32'hFFFF_FFFF);
        send_item(CMD_RD_DET, 32'h0);
        send_item(CMD_RD_DISP, 32'h0);
        send_item(CMD_RD_RAW_DISP, 32'h0);
        // fill raw, then a write into a full slot
        send_item(CMD_WR_RAW, 32'h0000_0000);
        send_item(CMD_WR_RAW, 32'hFFFF_FFFF);
        send_item(CMD_WR_RAW, 32'hDEAD_BEEF);
        // raw reads leave the flag set, so the wrapped head reads slot 0 again
        send_item(CMD_RD_RAW_DET, 32'h0);
        send_item(CMD_RD_RAW_DET, 32'h0);
        send_item(CMD_RD_RAW_DET, 32'h0);
        send_item(CMD_WR_DET, 32'hA5A5_A5A5);
        send_item(CMD_RD_DET, 32'h0);
        send_item(CMD_RD_DET, 32'h0);
        send_item(CMD_RD_RAW_DISP, 32'h0);
        send_item(CMD_WR_DISP, 32'h5A5A_5A5A);
        send_item(CMD_RD_DISP, 32'h0);
        // slot 0 of raw was freed by the display read
        send_item(CMD_WR_RAW, 32'h1234_5678);
        send_item(CMD_WR_RAW, 32'h8765_4321);
        send_item(CMD_NOP, 32'hFFFF_FFFF);
        send_item(CMD_WR_DISP, 32'hFFFF_FFFF);
        send_item(CMD_WR_DISP, 32'h0F0F_0F0F);
        send_item(CMD_WR_DISP, 32'hF0F0_F0F0);
    endtask

    task automatic test_ring_size(input logic [CFG_W-1:0] size, input int n);
        set_ring_size(size);
        run_traffic(n);
    endtask

    // Output held off long enough for the pipeline to fill and stall input
    task automatic test_backpressure();
        wait_idle();
        hold_req = 1'b1;
        repeat (20) send_item(CMD_W'($urandom_range(0, 7)), rand_desc());
        wait_idle();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_ring_size(5'd16, 50);
        test_ring_size(5'd3, 50);
        test_backpressure();
        test_ring_size(5'd1, 50);
        test_ring_size(5'd0, 50);
        test_ring_size(5'd31, 50);
        test_ring_size(5'd17, 50);
        test_ring_size(5'd8, 50);
        test_ring_size(5'd16, 50);
        wait_idle();
        repeat (10) @(posedge i_clk);

        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
            err_cnt++;
        end
        $display("Ran %0d commands across %0d ring-size writes (0 to 31), with stalls",
                 cmds_sent, cfg_writes);
        $display("Checked %0d results, %0d of them successful operations",
                 results_checked, ok_cnt);
        if (err_cnt == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/frt_pkg.sv
hdl/frt_ram.sv
hdl/frame_slot_ring_tracker.sv
sim/frame_slot_ring_tracker_tb.sv
